/* src/ahc_pkg.sv */
package ahc_pkg;

	// Width of the parsed value; the digit buffer and counters follow from it
	localparam int VALUE_WIDTH  = 32;
	localparam int HEX_DIGITS   = (VALUE_WIDTH + 3) / 4;
	// floor(VALUE_WIDTH * log10(2)) + 1 decimal digits cover all-ones
	localparam int DEC_DIGITS   = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int NUM_DIGITS   = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int DIGIT_BITS   = NUM_DIGITS * 4;
	localparam int DIGIT_CNT_W  = $clog2(NUM_DIGITS + 1);
	localparam int STEP_W       = $clog2(VALUE_WIDTH);

	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_ZERO     = 8'd48;
	localparam logic [7:0] CHAR_NINE     = 8'd57;
	localparam logic [7:0] CHAR_UPPER_A  = 8'd65;
	localparam logic [7:0] CHAR_UPPER_F  = 8'd70;
	localparam logic [7:0] CHAR_X        = 8'd120;
	localparam logic [7:0] CHAR_MINUS    = 8'd45;
	localparam logic [7:0] LETTER_OFFSET = 8'd55;

	// What the back end makes of a finished word
	typedef enum logic [1:0] {
		JOB_ECHO,
		JOB_TO_HEX,
		JOB_TO_DEC
	} job_kind_t;

	typedef struct packed {
		job_kind_t              kind;
		logic [VALUE_WIDTH-1:0] value;
		logic [7:0]             echo_char;
	} job_t;

	function automatic logic is_dec_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic is_hex_letter(input logic [7:0] c);
		return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F);
	endfunction

	// Digit value of '0'-'9' or 'A'-'F'
	function automatic logic [3:0] char_value(input logic [7:0] c);
		logic [3:0] low;
		low = c[3:0];
		return is_dec_digit(c) ? low : low + 4'd9;
	endfunction

	// acc * base + digit, clamped to all-ones
	function automatic logic [VALUE_WIDTH-1:0] sat_mac(
		input logic [VALUE_WIDTH-1:0] acc,
		input logic                   base_hex,
		input logic [3:0]             digit
	);
		logic [VALUE_WIDTH+3:0] scaled;
		logic [VALUE_WIDTH+3:0] wide;
		scaled = base_hex ? {acc, 4'h0} : ({3'b000, acc, 1'b0} + {1'b0, acc, 3'b000});
		wide   = scaled + {{VALUE_WIDTH{1'b0}}, digit};
		if (wide[VALUE_WIDTH+3:VALUE_WIDTH] != 4'h0) begin
			return '1;
		end
		return wide[VALUE_WIDTH-1:0];
	endfunction

	// Uppercase ASCII for one digit
	function automatic logic [7:0] digit_ascii(input logic [3:0] d);
		return (d < 4'd10) ? (CHAR_ZERO + {4'h0, d}) : (LETTER_OFFSET + {4'h0, d});
	endfunction

endpackage

/* src/ahc_in_if.sv */
interface ahc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       in_last;

	modport source (output valid, output in_char, output in_last, input ready);
	modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

/* src/ahc_out_if.sv */
interface ahc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;

	modport source (output valid, output out_char, output out_last, input ready);
	modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

/* src/ahc_front.sv */
module ahc_front import ahc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ahc_in_if.sink    char_ch,
	input  logic      queue_full,
	output logic      push,
	output job_t      push_job
);

	typedef enum logic [1:0] {
		POS_FIRST,
		POS_SECOND,
		POS_REST
	} pos_t;

	pos_t                   pos_q, pos_n;
	logic [VALUE_WIDTH-1:0] acc_q, acc_n;
	logic [7:0]             first_q, first_n;
	logic                   hex_q, hex_n;
	logic                   halted_q, halted_n;
	logic                   done_q, done_n;
	logic                   word_end;
	logic                   accept;
	logic [7:0]             c;
	logic                   last;
	logic [VALUE_WIDTH-1:0] first_val;

	assign char_ch.ready = !queue_full;
	assign accept        = char_ch.valid && char_ch.ready;
	assign c             = char_ch.in_char;
	assign last          = char_ch.in_last;
	assign first_val     = {{(VALUE_WIDTH-4){1'b0}}, char_value(first_q)};

	// Parse one character against the word state
	always_comb begin
		acc_n    = acc_q;
		pos_n    = pos_q;
		first_n  = first_q;
		hex_n    = hex_q;
		halted_n = halted_q;
		done_n   = done_q;
		word_end = 1'b0;
		if (!done_q) begin
			unique case (pos_q)
				POS_FIRST: begin
					if (c == CHAR_MINUS) begin
						done_n = 1'b1;
					end else begin
						first_n = c;
						if (last) begin
							word_end = 1'b1;
						end else begin
							pos_n = POS_SECOND;
						end
					end
				end
				POS_SECOND: begin
					pos_n    = POS_REST;
					halted_n = 1'b0;
					if (c == CHAR_X) begin
						hex_n = 1'b1;
						acc_n = '0;
					end else begin
						hex_n = 1'b0;
						if (!is_dec_digit(first_q)) begin
							acc_n    = '0;
							halted_n = 1'b1;
						end else if (is_dec_digit(c)) begin
							acc_n = sat_mac(first_val, 1'b0, char_value(c));
						end else begin
							acc_n    = first_val;
							halted_n = 1'b1;
						end
					end
					word_end = last;
				end
				POS_REST: begin
					if (hex_q) begin
						if (is_dec_digit(c) || is_hex_letter(c)) begin
							acc_n = sat_mac(acc_q, 1'b1, char_value(c));
						end
					end else if (!halted_q) begin
						if (is_dec_digit(c)) begin
							acc_n = sat_mac(acc_q, 1'b0, char_value(c));
						end else begin
							halted_n = 1'b1;
						end
					end
					word_end = last;
				end
				default: begin
					word_end = 1'b0;
				end
			endcase
		end
	end

	// Hand the finished word to the back end
	always_comb begin
		push               = accept && word_end;
		push_job.value     = acc_n;
		push_job.echo_char = c;
		if (pos_q == POS_FIRST) begin
			push_job.kind = JOB_ECHO;
		end else if (hex_n) begin
			push_job.kind = JOB_TO_DEC;
		end else begin
			push_job.kind = JOB_TO_HEX;
		end
	end

	// Hold word state; clear it when the word ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_FIRST;
			acc_q    <= '0;
			first_q  <= '0;
			hex_q    <= 1'b0;
			halted_q <= 1'b0;
			done_q   <= 1'b0;
		end else if (accept) begin
			done_q <= done_n;
			if (word_end) begin
				pos_q    <= POS_FIRST;
				acc_q    <= '0;
				first_q  <= '0;
				hex_q    <= 1'b0;
				halted_q <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				acc_q    <= acc_n;
				first_q  <= first_n;
				hex_q    <= hex_n;
				halted_q <= halted_n;
			end
		end
	end

endmodule

/* src/ahc_queue.sv */
module ahc_queue import ahc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	job_t                   slots_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_ptr_q];

	function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
		return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Store a request
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/ahc_back.sv */
module ahc_back import ahc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  logic      queue_empty,
	output logic      pop,
	ahc_out_if.source text_ch
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PFX_ZERO,
		ST_PFX_X,
		ST_ECHO,
		ST_DABBLE,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	job_kind_t                       kind_q;
	logic [7:0]                      echo_q;
	logic [NUM_DIGITS-1:0][3:0]      dig_q;
	logic [NUM_DIGITS-1:0][3:0]      adj;
	logic [DIGIT_BITS:0]             dabble_w;
	logic [VALUE_WIDTH-1:0]          bin_q;
	logic [STEP_W-1:0]               step_q;
	logic [DIGIT_CNT_W-1:0]          cnt_q;
	logic                            out_valid_q;
	logic [7:0]                      out_char_q;
	logic                            out_last_q;
	logic                            can_load;
	logic                            load;
	logic [3:0]                      top_digit;

	assign text_ch.valid    = out_valid_q;
	assign text_ch.out_char = out_char_q;
	assign text_ch.out_last = out_last_q;

	assign pop       = (state_q == ST_IDLE) && !queue_empty;
	assign can_load  = !out_valid_q || text_ch.ready;
	assign top_digit = dig_q[NUM_DIGITS-1];

	// Load the output register in every state that sends a character
	assign load = can_load && ((state_q == ST_PFX_ZERO) || (state_q == ST_PFX_X)
		|| (state_q == ST_ECHO) || (state_q == ST_EMIT));

	// Add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
		end
		dabble_w = {adj, bin_q[VALUE_WIDTH-1]};
	end

	// Sequence one request: prefix, echoed character or conversion, digit output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= JOB_ECHO;
			echo_q      <= '0;
			dig_q       <= '0;
			bin_q       <= '0;
			step_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// Hold the output request until taken
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (text_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						kind_q <= head.kind;
						echo_q <= head.echo_char;
						bin_q  <= head.value;
						step_q <= '0;
						cnt_q  <= DIGIT_CNT_W'(NUM_DIGITS);
						if (head.kind == JOB_TO_DEC) begin
							dig_q   <= '0;
							state_q <= ST_DABBLE;
						end else begin
							dig_q   <= DIGIT_BITS'(head.value);
							state_q <= ST_PFX_ZERO;
						end
					end
				end
				ST_PFX_ZERO: begin
					if (can_load) begin
						out_char_q  <= CHAR_ZERO;
						out_last_q  <= 1'b0;
						state_q     <= ST_PFX_X;
					end
				end
				ST_PFX_X: begin
					if (can_load) begin
						out_char_q  <= CHAR_X;
						out_last_q  <= 1'b0;
						state_q     <= (kind_q == JOB_ECHO) ? ST_ECHO : ST_SKIP;
					end
				end
				ST_ECHO: begin
					if (can_load) begin
						out_char_q  <= echo_q;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_DABBLE: begin
					dig_q  <= dabble_w[DIGIT_BITS-1:0];
					bin_q  <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(VALUE_WIDTH - 1)) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// drop leading zeros, keep at least one digit
					if (top_digit == 4'h0 && cnt_q > DIGIT_CNT_W'(1)) begin
						dig_q <= {dig_q[NUM_DIGITS-2:0], 4'h0};
						cnt_q <= cnt_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (can_load) begin
						out_char_q  <= digit_ascii(top_digit);
						out_last_q  <= (cnt_q == DIGIT_CNT_W'(1));
						dig_q       <= {dig_q[NUM_DIGITS-2:0], 4'h0};
						cnt_q       <= cnt_q - 1'b1;
						if (cnt_q == DIGIT_CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/ascii_dec_hex_base_converter.sv */
// Channel   Modport  Payload             Moves
// char_ch   sink     in_char, in_last    one character of a word
// text_ch   source   out_char, out_last  one character of the converted text
//
// The front parses one character per cycle while the queue is not full; finished words wait in a two-entry queue.
// The back fetches a word from the queue, runs shift-add-3 over every value bit for a
// hex word, drops leading zeros one digit at a time, and then sends the characters of
// the converted text.
// Input stalls only while the queue is full; output stalls hold the back end alone.
// arst_n clears all control state; the block is ready once reset is released.
module ascii_dec_hex_base_converter import ahc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ahc_in_if.sink    char_ch,
	ahc_out_if.source text_ch
);

	job_t push_job;
	job_t head;
	logic push;
	logic pop;
	logic queue_empty;
	logic queue_full;

	ahc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_ch    (char_ch),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	ahc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (queue_empty),
		.full     (queue_full)
	);

	ahc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.queue_empty (queue_empty),
		.pop         (pop),
		.text_ch     (text_ch)
	);

endmodule

/* src/ahc_checker.sv */
module ahc_checker import ahc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [7:0] out_char,
	input logic       out_last
);

	logic taken;
	logic word_start_q;
	logic zero_open_q;

	assign taken = valid && ready;

	// Track where the output text stands within a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_start_q <= 1'b1;
			zero_open_q  <= 1'b0;
		end else if (taken) begin
			word_start_q <= out_last;
			zero_open_q  <= word_start_q && (out_char == CHAR_ZERO) && !out_last;
		end
	end

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("output request dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(out_char) && $stable(out_last))
		else $error("output payload changed while stalled");

	a_word_opens_digit: assert property (@(posedge clk) disable iff (!arst_n)
		taken && word_start_q |-> (out_char >= CHAR_ZERO) && (out_char <= CHAR_NINE))
		else $error("converted word does not open with a digit");

	a_prefix_x: assert property (@(posedge clk) disable iff (!arst_n)
		taken && zero_open_q |-> out_char == CHAR_X)
		else $error("leading zero not followed by x");

endmodule

bind ascii_dec_hex_base_converter ahc_checker u_ahc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.valid    (text_ch.valid),
	.ready    (text_ch.ready),
	.out_char (text_ch.out_char),
	.out_last (text_ch.out_last)
);

/* sim/ahc_text_checker.sv */
`timescale 1ns / 100ps

// Watches both channels, predicts the converted text for every accepted
// character and compares each text character leaving the block in order.
module ahc_text_checker import ahc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ahc_in_if    chars,
	ahc_out_if   text,
	output int   errors,
	output int   pending
);

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	// Text characters predicted but not yet seen, oldest first
	text_char_t text_due[$];

	// Own copy of the parser state
	logic [VALUE_WIDTH-1:0] acc;
	logic [1:0]             pos;
	logic [7:0]             lead_char;
	logic                   hex_word;
	logic                   halted;
	logic                   stopped;
	int                     fault_cnt;

	// acc * base + digit, pinned at all-ones when it no longer fits
	function automatic logic [VALUE_WIDTH-1:0] mac_clamped(
		input logic [VALUE_WIDTH-1:0] a,
		input logic                   base16,
		input logic [3:0]             digit
	);
		logic [VALUE_WIDTH+7:0] wacc;
		logic [VALUE_WIDTH+7:0] wbase;
		logic [VALUE_WIDTH+7:0] wdig;
		logic [VALUE_WIDTH+7:0] wide;
		wacc  = {8'h00, a};
		wbase = base16 ? (VALUE_WIDTH+8)'(16) : (VALUE_WIDTH+8)'(10);
		wdig  = {{(VALUE_WIDTH+4){1'b0}}, digit};
		wide  = wacc * wbase + wdig;
		if (wide[VALUE_WIDTH+7:VALUE_WIDTH] != 8'h00) begin
			return '1;
		end
		return wide[VALUE_WIDTH-1:0];
	endfunction

	function automatic void queue_char(input logic [7:0] ch, input logic last);
		text_char_t t;
		t.ch   = ch;
		t.last = last;
		text_due.push_back(t);
	endfunction

	task automatic clear_word();
		acc       = '0;
		pos       = 2'd0;
		lead_char = 8'h00;
		hex_word  = 1'b0;
		halted    = 1'b0;
	endtask

	// Decimal digits until the first non-digit, then ignore the rest
	task automatic take_dec(input logic [7:0] c);
		if (!halted) begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				acc = mac_clamped(acc, 1'b0, 4'(c - CHAR_ZERO));
			end else begin
				halted = 1'b1;
			end
		end
	endtask

	// Uppercase hex digits only; skip everything else
	task automatic take_hex(input logic [7:0] c);
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			acc = mac_clamped(acc, 1'b1, 4'(c - CHAR_ZERO));
		end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
			acc = mac_clamped(acc, 1'b1, 4'(c - CHAR_UPPER_A + 8'd10));
		end
	endtask

	// Hex words come out in decimal, decimal words as 0x plus hex
	task automatic emit_word();
		logic [7:0]             digits [0:23];
		int                     n;
		logic [VALUE_WIDTH-1:0] v;
		logic [3:0]             d;
		v = acc;
		n = 0;
		if (hex_word) begin
			do begin
				digits[n] = CHAR_ZERO + 8'(v % 10);
				v = v / 10;
				n++;
			end while (v != 0);
		end else begin
			queue_char(CHAR_ZERO, 1'b0);
			queue_char(CHAR_X, 1'b0);
			do begin
				d = v[3:0];
				digits[n] = (d < 4'd10) ? CHAR_ZERO + {4'h0, d}
					: CHAR_UPPER_A - 8'd10 + {4'h0, d};
				v = v >> 4;
				n++;
			end while (v != 0);
		end
		while (n > 0) begin
			n--;
			queue_char(digits[n], n == 0);
		end
	endtask

	// Advance the prediction by one accepted character
	task automatic convert_char(input logic [7:0] c, input logic last);
		if (!stopped) begin
			if (pos == 2'd0) begin
				if (c == CHAR_MINUS) begin
					stopped = 1'b1;
				end else if (last) begin
					// A lone character is echoed behind 0x
					queue_char(CHAR_ZERO, 1'b0);
					queue_char(CHAR_X, 1'b0);
					queue_char(c, 1'b1);
					clear_word();
				end else begin
					lead_char = c;
					pos       = 2'd1;
				end
			end else begin
				if (pos == 2'd1) begin
					acc      = '0;
					hex_word = (c == CHAR_X);
					if (!hex_word) begin
						take_dec(lead_char);
						take_dec(c);
					end
					pos = 2'd2;
				end else if (hex_word) begin
					take_hex(c);
				end else begin
					take_dec(c);
				end
				if (last) begin
					emit_word();
					clear_word();
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			clear_word();
			stopped   = 1'b0;
			fault_cnt = 0;
			text_due.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			// Compare each leaving character with the oldest prediction
			if (text.valid && text.ready) begin
				if (text_due.size() == 0) begin
					fault_cnt++;
					if (fault_cnt <= 10) begin
						$display("%0t: unexpected text char %h last %b",
							$realtime, text.out_char, text.out_last);
					end
				end else begin
					want = text_due.pop_front();
					if (text.out_char !== want.ch || text.out_last !== want.last) begin
						fault_cnt++;
						if (fault_cnt <= 10) begin
							$display("%0t: text char expected %h last %b, got %h last %b",
								$realtime, want.ch, want.last, text.out_char, text.out_last);
						end
					end
				end
			end
			if (chars.valid && chars.ready) begin
				convert_char(chars.in_char, chars.in_last);
			end
			errors  <= fault_cnt;
			pending <= text_due.size();
		end
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import ahc_pkg::*;

	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam int RANDOM_ITEMS = 280;
	localparam int HOLD_START   = 300;
	localparam int HOLD_LEN     = 250;
	localparam int CALM_START   = 900;
	localparam int CALM_END     = 1200;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 100;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   sent_cnt;
	int   stall_cnt;
	int   rx_cyc;
	logic [7:0] word_buf[$];

	ahc_in_if  char_ch();
	ahc_out_if text_ch();

	ascii_dec_hex_base_converter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_ch),
		.text_ch (text_ch)
	);

	ahc_text_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (char_ch),
		.text    (text_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one character, idling now and then, and hold it until taken
	task automatic send_char(input logic [7:0] c, input logic last);
		logic calm;
		calm = (sent_cnt >= 150 && sent_cnt < 210);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 12) begin
			char_ch.valid <= 1'b0;
			@(negedge clk);
		end
		char_ch.valid   <= 1'b1;
		char_ch.in_char <= c;
		char_ch.in_last <= last;
		@(posedge clk);
		while (!char_ch.ready) @(posedge clk);
		sent_cnt++;
	endtask

	task automatic send_word();
		for (int i = 0; i < word_buf.size(); i++) begin
			send_char(word_buf[i], i == word_buf.size() - 1);
		end
		word_buf.delete();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			word_buf.push_back(s[i]);
		end
	endtask

	// Mostly well-formed decimal and hex words, some lone characters and noise
	task automatic build_random_word();
		int         kind;
		int         len;
		int         d;
		logic [7:0] c;
		word_buf.delete();
		kind = $urandom_range(99);
		if (kind < 35) begin
			len = $urandom_range(2, 12);
			for (int i = 0; i < len; i++) begin
				word_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
			end
			if ($urandom_range(3) == 0) begin
				word_buf[$urandom_range(1, len - 1)] = 8'($urandom_range(255));
			end
		end else if (kind < 70) begin
			c = 8'($urandom_range(255));
			word_buf.push_back((c == CHAR_MINUS) ? CHAR_ZERO : c);
			word_buf.push_back(CHAR_X);
			len = $urandom_range(0, 10);
			for (int i = 0; i < len; i++) begin
				d = $urandom_range(15);
				if ($urandom_range(9) < 7) begin
					word_buf.push_back((d < 10) ? CHAR_ZERO + 8'(d)
						: CHAR_UPPER_A + 8'(d - 10));
				end else begin
					word_buf.push_back(8'($urandom_range(255)));
				end
			end
		end else if (kind < 82) begin
			c = 8'($urandom_range(255));
			word_buf.push_back((c == CHAR_MINUS) ? CHAR_NINE : c);
		end else begin
			len = $urandom_range(2, 6);
			for (int i = 0; i < len; i++) begin
				word_buf.push_back(8'($urandom_range(255)));
			end
			if (word_buf[0] == CHAR_MINUS) begin
				word_buf[0] = CHAR_UPPER_Z;
			end
		end
	endtask

	// Stimulus and verdict
	initial begin
		arst_n          = 1'b0;
		char_ch.valid   = 1'b0;
		char_ch.in_char = 8'h00;
		char_ch.in_last = 1'b0;
		sent_cnt        = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Lone characters at both extremes of the byte
		word_buf.push_back(8'h00);
		send_word();
		word_buf.push_back(8'hFF);
		send_word();
		// A plus sign is no sign: decimal value zero
		push_text("+5");
		send_word();
		// Hex word with no digits at all
		push_text("0x");
		send_word();
		// Skip lowercase, a dash, a plus sign and a high byte inside hex
		word_buf.push_back(CHAR_NINE);
		word_buf.push_back(CHAR_X);
		word_buf.push_back(CHAR_UPPER_A);
		word_buf.push_back(CHAR_MINUS);
		word_buf.push_back(CHAR_LOWER_F);
		word_buf.push_back(CHAR_PLUS);
		word_buf.push_back(8'h80);
		word_buf.push_back(CHAR_UPPER_F);
		send_word();
		// Hex overflow pins the value at all-ones
		push_text("0xFFFFFFFFF");
		send_word();

		sent_cnt = 0;
		while (sent_cnt < RANDOM_ITEMS) begin
			build_random_word();
			send_word();
		end

		// A word led by a dash ends the stream; nothing after it converts
		push_text("-7");
		send_word();
		push_text("5");
		send_word();
		push_text("0x1F");
		send_word();
		@(negedge clk);
		char_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("ascii_dec_hex_base_converter test passed");
		end else begin
			$display("ascii_dec_hex_base_converter test failed");
		end
		$finish;
	end

	// Text receiver: random stalls, one long hold-off, one calm stretch
	initial begin
		text_ch.ready = 1'b0;
		rx_cyc        = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			rx_cyc++;
			if (rx_cyc >= HOLD_START && rx_cyc < HOLD_START + HOLD_LEN) begin
				text_ch.ready <= 1'b0;
			end else if (rx_cyc >= CALM_START && rx_cyc < CALM_END) begin
				text_ch.ready <= 1'b1;
			end else begin
				text_ch.ready <= ($urandom_range(99) >= 12);
			end
		end
	end

	// Drop the run if no request moves on either channel for too long
	initial begin
		stall_cnt = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (char_ch.valid && char_ch.ready)
					|| (text_ch.valid && text_ch.ready)) begin
				stall_cnt = 0;
			end else begin
				stall_cnt++;
			end
			if (stall_cnt >= STALL_LIMIT) begin
				$display("ascii_dec_hex_base_converter test failed");
				$finish;
			end
		end
	end

endmodule
